/* rtl/atd_pkg.sv */
// Shared types and constants for the AT reply +IPD deframer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package atd_pkg;

	// Number of length digits taken into the frame length
	localparam int MAX_DIGITS = 4;
	localparam int DIGIT_W    = $clog2(MAX_DIGITS + 1);
	localparam int LEN_W      = 14;
	localparam int BYTE_W     = 8;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// Operation codes
	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	// Characters of interest
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// Payload part of one result item
	typedef struct packed {
		logic              payload_valid;
		logic [BYTE_W-1:0] payload_byte;
		logic              payload_last;
		logic [LEN_W-1:0]  payload_length;
	} frame_res_t;

	// One complete result item
	typedef struct packed {
		frame_res_t frame;
		logic       reply_seen;
	} result_t;

endpackage

/* rtl/atd_frame_parser.sv */
// Header matcher, length reader and payload pass-through for +IPD frames.
// Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_frame_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        operation,
	input  logic [atd_pkg::BYTE_W-1:0]  rx_byte,
	output atd_pkg::frame_res_t         res
);
	import atd_pkg::*;

	localparam int PROD_W = LEN_W + 4;

	typedef enum logic [2:0] {
		PH_PLUS, PH_I, PH_P, PH_D, PH_COMMA, PH_LEN, PH_DATA
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [DIGIT_W-1:0] digit_count_q, digit_count_d;
	logic               number_ended_q, number_ended_d;
	logic [LEN_W-1:0]   frame_length_q, frame_length_d;
	logic [LEN_W-1:0]   bytes_passed_q, bytes_passed_d;
	logic [BYTE_W-1:0]  hdr_char;
	logic               is_digit;
	logic [PROD_W-1:0]  len_ext;
	logic [PROD_W-1:0]  len_next;
	logic [LEN_W-1:0]   passed_inc;

	// Expected header character for the current phase
	always_comb begin
		unique case (phase_q)
			PH_PLUS:  hdr_char = CH_PLUS;
			PH_I:     hdr_char = CH_I;
			PH_P:     hdr_char = CH_P;
			PH_D:     hdr_char = CH_D;
			PH_COMMA: hdr_char = CH_COMMA;
			default:  hdr_char = CH_PLUS;
		endcase
	end

	// Length accumulate: times ten by shift and add, then saturate
	assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign len_ext    = PROD_W'(frame_length_q);
	assign len_next   = (len_ext << 3) + (len_ext << 1) + PROD_W'(rx_byte - CH_ZERO);
	assign passed_inc = bytes_passed_q + LEN_W'(1);

	// Next state and result
	always_comb begin
		phase_d        = phase_q;
		digit_count_d  = digit_count_q;
		number_ended_d = number_ended_q;
		frame_length_d = frame_length_q;
		bytes_passed_d = bytes_passed_q;
		res            = '0;
		if (operation == OP_RX_BYTE) begin
			unique case (phase_q)
				PH_PLUS, PH_I, PH_P, PH_D, PH_COMMA: begin
					if (rx_byte == hdr_char) begin
						phase_d = phase_t'(phase_q + 3'd1);
						if (phase_q == PH_COMMA) begin
							digit_count_d  = '0;
							number_ended_d = 1'b0;
							frame_length_d = '0;
						end
					end else begin
						phase_d = PH_PLUS;
					end
				end
				PH_LEN: begin
					if (rx_byte == CH_COLON) begin
						bytes_passed_d = '0;
						phase_d = (frame_length_q == '0) ? PH_PLUS : PH_DATA;
					end else if (is_digit) begin
						if (!number_ended_q && digit_count_q < DIGIT_W'(MAX_DIGITS)) begin
							frame_length_d = (len_next > PROD_W'(LEN_MAX)) ? LEN_MAX
								: len_next[LEN_W-1:0];
							digit_count_d  = digit_count_q + DIGIT_W'(1);
						end
					end else begin
						number_ended_d = 1'b1;
					end
				end
				PH_DATA: begin
					bytes_passed_d           = passed_inc;
					res.payload_valid        = 1'b1;
					res.payload_byte         = rx_byte;
					res.payload_length       = frame_length_q;
					if (passed_inc >= frame_length_q) begin
						res.payload_last = 1'b1;
						phase_d          = PH_PLUS;
					end
				end
				default: phase_d = PH_PLUS;
			endcase
		end
	end

	// Hold framing state between items, advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_PLUS;
			digit_count_q  <= '0;
			number_ended_q <= 1'b0;
			frame_length_q <= '0;
			bytes_passed_q <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			digit_count_q  <= digit_count_d;
			number_ended_q <= number_ended_d;
			frame_length_q <= frame_length_d;
			bytes_passed_q <= bytes_passed_d;
		end
	end

endmodule

/* rtl/atd_ready_detect.sv */
// Sticky ready flag: set on '>' or on "OK" while clear, cleared by operation.
// Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_ready_detect (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        operation,
	input  logic [atd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        reply_seen
);
	import atd_pkg::*;

	logic ready_q, ready_d;
	logic ok_phase_q, ok_phase_d;
	logic ready_gt;

	// Flag after this item; '>' wins before the letter pair is looked at
	always_comb begin
		ready_gt   = ready_q | (rx_byte == CH_GT);
		ready_d    = ready_q;
		ok_phase_d = ok_phase_q;
		if (operation == OP_CLEAR) begin
			ready_d = 1'b0;
		end else begin
			ready_d = ready_gt;
			if (!ready_gt) begin
				if (!ok_phase_q) begin
					ok_phase_d = (rx_byte == CH_O);
				end else begin
					ok_phase_d = 1'b0;
					ready_d    = (rx_byte == CH_K);
				end
			end
		end
	end

	assign reply_seen = ready_d;

	// Advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q    <= 1'b0;
			ok_phase_q <= 1'b0;
		end else if (step) begin
			ready_q    <= ready_d;
			ok_phase_q <= ok_phase_d;
		end
	end

endmodule

/* rtl/atd_out_skid.sv */
// Result register with a skid stage, so an item is taken while a result waits.
// Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  atd_pkg::result_t  push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output atd_pkg::result_t  out_data
);
	import atd_pkg::*;

	logic    out_valid_q;
	logic    skid_full_q;
	result_t out_q;
	result_t skid_q;
	logic    take;

	assign take      = out_valid_q & ~out_stall;
	assign full      = skid_full_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Occupancy of result and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (take) begin
			if (skid_full_q) begin
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_full_q <= 1'b1;
		end
	end

	// Payload moves, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_full_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (!out_valid_q) begin
			if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

/* rtl/at_reply_ipd_deframer_core.sv */
// Top level of the AT reply +IPD deframer.
// Depends on atd_pkg, atd_frame_parser, atd_ready_detect and atd_out_skid.
`timescale 1ns / 1ps

// One received byte (or a clear of the reply flag) enters per cycle while
// in_stall is low and gives exactly one result item, held in the result
// or skid register. Framing and reply-flag state update from the registered
// state and the incoming item; the result register plus a one-entry skid
// stage let the block keep accepting while the downstream side stalls, and
// in_stall rises only when both are full. Sustained rate is one item per clock while out_stall is low.
module at_reply_ipd_deframer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [atd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        payload_valid,
	output logic [atd_pkg::BYTE_W-1:0]  payload_byte,
	output logic                        payload_last,
	output logic [atd_pkg::LEN_W-1:0]   payload_length,
	output logic                        reply_seen
);
	import atd_pkg::*;

	logic       accept;
	logic       skid_full;
	frame_res_t frame_res;
	logic       reply_next;
	result_t    res_in;
	result_t    res_out;

	assign in_stall = skid_full;
	assign accept   = in_valid & ~skid_full;

	atd_frame_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.operation (operation),
		.rx_byte   (rx_byte),
		.res       (frame_res)
	);

	atd_ready_detect u_ready (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.operation  (operation),
		.rx_byte    (rx_byte),
		.reply_seen (reply_next)
	);

	// Assemble the result item
	assign res_in.frame      = frame_res;
	assign res_in.reply_seen = reply_next;

	atd_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_in),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign payload_valid  = res_out.frame.payload_valid;
	assign payload_byte   = res_out.frame.payload_byte;
	assign payload_last   = res_out.frame.payload_last;
	assign payload_length = res_out.frame.payload_length;
	assign reply_seen     = res_out.reply_seen;

endmodule

/* rtl/atd_checker.sv */
// Port-level checks for the AT reply +IPD deframer, bound to the top level.
// Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        payload_valid,
	input  logic [atd_pkg::BYTE_W-1:0]  payload_byte,
	input  logic                        payload_last,
	input  logic [atd_pkg::LEN_W-1:0]   payload_length,
	input  logic                        reply_seen
);
	import atd_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(payload_length) && $stable(reply_seen))
		else $error("stalled result changed");

	// Last marks only payload items
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_last |-> payload_valid)
		else $error("last without payload");

	// Non-payload items carry zero byte and length
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == '0 && payload_length == '0)
		else $error("non-payload item carries data");

	// A frame with payload never announces zero length
	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> payload_length != '0)
		else $error("payload with zero length");

endmodule

bind at_reply_ipd_deframer_core atd_checker u_atd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.payload_valid  (payload_valid),
	.payload_byte   (payload_byte),
	.payload_last   (payload_last),
	.payload_length (payload_length),
	.reply_seen     (reply_seen)
);

/* test/tb_at_reply_ipd_deframer_core.sv */
// Self-checking testbench for the +IPD deframer core: a directed table, then random
// modem traffic, each result checked against a typed-in row or a cycle-free predictor.
// Depends on atd_pkg and at_reply_ipd_deframer_core.
`timescale 1ns / 1ps

module tb_at_reply_ipd_deframer_core;

	import atd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int unsigned DIR_ROWS     = 25;
	localparam int unsigned SETTLE       = 10;
	localparam int unsigned TAIL_BYTES   = 16;

	// Where the predictor is in the header / length / payload walk
	typedef enum logic [2:0] {
		HUNT_PLUS, WANT_I, WANT_P, WANT_D, WANT_COMMA, READ_LEN, PASS_DATA
	} hdr_phase_e;

	// One row of the directed table
	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] ch;
		logic              pinned;
		result_t           want;
	} dir_row_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              operation = OP_RX_BYTE;
	logic [BYTE_W-1:0] rx_byte   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              payload_valid;
	logic [BYTE_W-1:0] payload_byte;
	logic              payload_last;
	logic [LEN_W-1:0]  payload_length;
	logic              reply_seen;

	// Typed-in expectation travelling with the item being offered
	logic              pin_on   = 1'b0;
	result_t           pin_want = '0;

	result_t           awaited_results [$];
	dir_row_t          script [DIR_ROWS];
	int unsigned       mismatches  = 0;
	int unsigned       cycles      = 0;
	int unsigned       items_sent  = 0;
	int unsigned       burst_left  = 0;
	bit                rx_hold     = 1'b0;
	int unsigned       rx_seg_left = 0;

	// Predictor state
	hdr_phase_e         phase_q    = HUNT_PLUS;
	logic [DIGIT_W-1:0] digits_q   = '0;
	logic               len_done_q = 1'b0;
	logic [LEN_W-1:0]   len_q      = '0;
	logic [LEN_W-1:0]   passed_q   = '0;
	logic               saw_o_q    = 1'b0;
	logic               flag_q     = 1'b0;

	at_reply_ipd_deframer_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_valid  (payload_valid),
		.payload_byte   (payload_byte),
		.payload_last   (payload_last),
		.payload_length (payload_length),
		.reply_seen     (reply_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [BYTE_W-1:0] header_char(input int unsigned idx);
		case (idx)
			0: return CH_PLUS;
			1: return CH_I;
			2: return CH_P;
			3: return CH_D;
			default: return CH_COMMA;
		endcase
	endfunction

	// Advance the predictor by one item and return the result it gives
	function automatic result_t deframe_next(input logic op, input logic [BYTE_W-1:0] ch);
		result_t          res;
		logic [LEN_W+3:0] grown;
		res = '0;
		if (op == OP_CLEAR) begin
			flag_q = 1'b0;
		end else begin
			case (phase_q)
				HUNT_PLUS, WANT_I, WANT_P, WANT_D, WANT_COMMA: begin
					// a wrong byte drops back to hunting without being retried as '+'
					if (ch != header_char(int'(phase_q))) begin
						phase_q = HUNT_PLUS;
					end else if (phase_q == WANT_COMMA) begin
						phase_q    = READ_LEN;
						digits_q   = '0;
						len_done_q = 1'b0;
						len_q      = '0;
					end else begin
						phase_q = hdr_phase_e'(phase_q + 3'd1);
					end
				end
				READ_LEN: begin
					if (ch == CH_COLON) begin
						passed_q = '0;
						phase_q  = (len_q == '0) ? HUNT_PLUS : PASS_DATA;
					end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
						if (!len_done_q && digits_q < MAX_DIGITS) begin
							grown    = (LEN_W+4)'(len_q) * (LEN_W+4)'(10)
								+ (LEN_W+4)'(ch - CH_ZERO);
							len_q    = (grown > LEN_MAX) ? LEN_MAX : grown[LEN_W-1:0];
							digits_q = digits_q + 1'b1;
						end
					end else begin
						len_done_q = 1'b1;
					end
				end
				PASS_DATA: begin
					passed_q                   = passed_q + 1'b1;
					res.frame.payload_valid    = 1'b1;
					res.frame.payload_byte     = ch;
					res.frame.payload_length   = len_q;
					if (passed_q >= len_q) begin
						res.frame.payload_last = 1'b1;
						phase_q                = HUNT_PLUS;
					end
				end
				default: phase_q = HUNT_PLUS;
			endcase

			// watch every received byte for the prompt or an OK reply
			if (ch == CH_GT)
				flag_q = 1'b1;
			if (!flag_q) begin
				if (!saw_o_q) begin
					saw_o_q = (ch == CH_O);
				end else begin
					saw_o_q = 1'b0;
					if (ch == CH_K)
						flag_q = 1'b1;
				end
			end
		end
		res.reply_seen = flag_q;
		return res;
	endfunction

	function automatic dir_row_t pinned_row(input logic op, input logic [BYTE_W-1:0] ch,
			input logic pv, input logic [BYTE_W-1:0] pb, input logic pl,
			input logic [LEN_W-1:0] plen, input logic rs);
		dir_row_t row;
		row.op                        = op;
		row.ch                        = ch;
		row.pinned                    = 1'b1;
		row.want.frame.payload_valid  = pv;
		row.want.frame.payload_byte   = pb;
		row.want.frame.payload_last   = pl;
		row.want.frame.payload_length = plen;
		row.want.reply_seen           = rs;
		return row;
	endfunction

	function automatic dir_row_t open_row(input logic op, input logic [BYTE_W-1:0] ch);
		dir_row_t row;
		row        = '0;
		row.op     = op;
		row.ch     = ch;
		return row;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_non_digit();
		logic [BYTE_W-1:0] ch;
		do
			ch = BYTE_W'($urandom_range(0, 255));
		while ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_COLON);
		return ch;
	endfunction

	// Mostly random bytes, leaning on the characters the block reacts to
	function automatic logic [BYTE_W-1:0] pick_line_char();
		logic [BYTE_W-1:0] ch;
		case ($urandom_range(0, 9))
			0: ch = CH_GT;
			1: ch = CH_O;
			2: ch = CH_K;
			3: ch = CH_PLUS;
			default: ch = BYTE_W'($urandom_range(0, 255));
		endcase
		return ch;
	endfunction

	// Offer one item in bursts with random gaps; return at the edge that takes it
	task automatic offer(input logic op, input logic [BYTE_W-1:0] ch, input logic pinned,
			input result_t want);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		in_valid  <= 1'b1;
		operation <= op;
		rx_byte   <= ch;
		pin_on    <= pinned;
		pin_want  <= want;
		items_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic feed_byte(input logic [BYTE_W-1:0] ch);
		offer(OP_RX_BYTE, ch, 1'b0, '0);
	endtask

	task automatic feed_clear();
		offer(OP_CLEAR, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// Hold the sender off until every expected result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// Send a well-formed frame, with varied digit formatting and stray clears
	task automatic send_frame(input int unsigned frame_len);
		int unsigned width;
		int unsigned scale;
		int unsigned junk;
		int unsigned i;
		for (i = 0; i < 5; i++)
			feed_byte(header_char(i));
		junk  = $urandom_range(0, 5);
		width = (frame_len > 999) ? 4 : (frame_len > 99) ? 3 : (frame_len > 9) ? 2 : 1;
		if (junk == 0)
			width = MAX_DIGITS;
		else if ($urandom_range(0, 3) == 0)
			width = $urandom_range(width, MAX_DIGITS);
		scale = 1;
		for (i = 1; i < width; i++)
			scale = scale * 10;
		for (i = 0; i < width; i++) begin
			feed_byte(CH_ZERO + BYTE_W'((frame_len / scale) % 10));
			scale = scale / 10;
		end
		// digits past the limit, or a non-digit that ends the number
		if (junk == 0) begin
			repeat ($urandom_range(1, 2)) feed_byte(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
		end else if (junk == 1) begin
			feed_byte(pick_non_digit());
			repeat ($urandom_range(0, 2)) feed_byte(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
		end
		feed_byte(CH_COLON);
		for (i = 0; i < frame_len; i++) begin
			if ($urandom_range(0, 19) == 0)
				feed_clear();
			feed_byte(pick_line_char());
		end
	endtask

	// Stall the result side in segments of random length
	always @(posedge clk) begin
		if (rx_seg_left == 0) begin
			rx_hold     = !rx_hold;
			rx_seg_left = rx_hold ? $urandom_range(1, 6)
				: (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4));
		end
		rx_seg_left--;
		out_stall <= rx_hold;
	end

	// Predict each accepted item and check each accepted result
	always @(posedge clk) begin : check_results
		result_t predicted;
		result_t oldest;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted = deframe_next(operation, rx_byte);
				awaited_results.push_back(pin_on ? pin_want : predicted);
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result item arrived with nothing expected");
					mismatches++;
				end else begin
					oldest = awaited_results.pop_front();
					if (payload_valid !== oldest.frame.payload_valid) begin
						$error("payload_valid: expected %0d, got %0d",
							oldest.frame.payload_valid, payload_valid);
						mismatches++;
					end
					if (payload_byte !== oldest.frame.payload_byte) begin
						$error("payload_byte: expected %02h, got %02h",
							oldest.frame.payload_byte, payload_byte);
						mismatches++;
					end
					if (payload_last !== oldest.frame.payload_last) begin
						$error("payload_last: expected %0d, got %0d",
							oldest.frame.payload_last, payload_last);
						mismatches++;
					end
					if (payload_length !== oldest.frame.payload_length) begin
						$error("payload_length: expected %0d, got %0d",
							oldest.frame.payload_length, payload_length);
						mismatches++;
					end
					if (reply_seen !== oldest.reply_seen) begin
						$error("reply_seen: expected %0d, got %0d",
							oldest.reply_seen, reply_seen);
						mismatches++;
					end
				end
			end
		end
	end

	// Give up if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned i;
		int unsigned k;
		int unsigned pick;
		bit          paused;

		// flag set and cleared, zero-length frame, short frame, doubled '+'
		script[0]  = pinned_row(OP_RX_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, 14'd0, 1'b0);
		script[1]  = pinned_row(OP_RX_BYTE, CH_GT, 1'b0, 8'h00, 1'b0, 14'd0, 1'b1);
		script[2]  = pinned_row(OP_CLEAR,   8'hFF, 1'b0, 8'h00, 1'b0, 14'd0, 1'b0);
		script[3]  = pinned_row(OP_RX_BYTE, CH_O,  1'b0, 8'h00, 1'b0, 14'd0, 1'b0);
		script[4]  = pinned_row(OP_RX_BYTE, CH_K,  1'b0, 8'h00, 1'b0, 14'd0, 1'b1);
		script[5]  = pinned_row(OP_CLEAR,   8'h00, 1'b0, 8'h00, 1'b0, 14'd0, 1'b0);
		script[6]  = open_row(OP_RX_BYTE, CH_PLUS);
		script[7]  = open_row(OP_RX_BYTE, CH_I);
		script[8]  = open_row(OP_RX_BYTE, CH_P);
		script[9]  = open_row(OP_RX_BYTE, CH_D);
		script[10] = open_row(OP_RX_BYTE, CH_COMMA);
		script[11] = pinned_row(OP_RX_BYTE, CH_COLON, 1'b0, 8'h00, 1'b0, 14'd0, 1'b0);
		script[12] = open_row(OP_RX_BYTE, CH_PLUS);
		script[13] = open_row(OP_RX_BYTE, CH_I);
		script[14] = open_row(OP_RX_BYTE, CH_P);
		script[15] = open_row(OP_RX_BYTE, CH_D);
		script[16] = open_row(OP_RX_BYTE, CH_COMMA);
		script[17] = open_row(OP_RX_BYTE, CH_ZERO + 8'd2);
		script[18] = open_row(OP_RX_BYTE, CH_COLON);
		script[19] = pinned_row(OP_RX_BYTE, 8'hFF, 1'b1, 8'hFF, 1'b0, 14'd2, 1'b0);
		script[20] = pinned_row(OP_RX_BYTE, CH_O,  1'b1, CH_O,  1'b1, 14'd2, 1'b0);
		script[21] = pinned_row(OP_RX_BYTE, CH_K,  1'b0, 8'h00, 1'b0, 14'd0, 1'b1);
		script[22] = open_row(OP_RX_BYTE, CH_PLUS);
		script[23] = open_row(OP_RX_BYTE, CH_PLUS);
		script[24] = pinned_row(OP_RX_BYTE, CH_I, 1'b0, 8'h00, 1'b0, 14'd0, 1'b1);
		paused     = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++)
			offer(script[i].op, script[i].ch, script[i].pinned, script[i].want);
		drain_results();

		// mostly well-formed frames, with broken headers, OK attempts and noise
		while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
			if (!paused && items_sent > DIR_ROWS + RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_frame($urandom_range(0, 12));
			end else if (pick < 62) begin
				send_frame($urandom_range(13, 120));
			end else if (pick < 70) begin
				feed_clear();
			end else if (pick < 78) begin
				feed_byte(CH_O);
				feed_byte($urandom_range(0, 1) ? CH_K : pick_line_char());
			end else if (pick < 86) begin
				k = $urandom_range(1, 4);
				for (i = 0; i < k; i++)
					feed_byte(header_char(i));
				feed_byte(pick_line_char());
			end else if (pick < 92) begin
				for (i = 0; i < 5; i++)
					feed_byte(header_char(i));
				feed_byte(pick_non_digit());
				feed_byte(CH_ZERO + BYTE_W'($urandom_range(1, 9)));
				feed_byte(CH_COLON);
			end else begin
				feed_byte(pick_line_char());
			end
		end

		// a frame announcing the largest four-digit length, left open after TAIL_BYTES payload bytes
		for (i = 0; i < 5; i++)
			feed_byte(header_char(i));
		repeat (MAX_DIGITS) feed_byte(CH_NINE);
		feed_byte(CH_COLON);
		repeat (TAIL_BYTES) feed_byte(pick_line_char());

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
